/* hw/rtl/rsm_pkg.sv */
// rsm_pkg: types and constants shared by the running set median block
// no dependencies; compile first

package rsm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = SAMPLE_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;

  typedef enum logic {
    S_FILL,
    S_DRAIN
  } rsm_state_t;

  // per cycle command broadcast to every cell of the row
  typedef struct packed {
    logic    ins;
    logic    drain;
    sample_t x;
  } cell_ctrl_t;

endpackage

/* hw/rtl/rsm_if.sv */
// rsm_in_if / rsm_out_if: valid/ready channels of the running set median block
// depends on rsm_pkg

interface rsm_in_if
  import rsm_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface rsm_out_if
  import rsm_pkg::*;
();
  logic    valid;
  logic    ready;
  median_t median_value;
  logic    status;

  modport source (output valid, output median_value, output status, input ready);
  modport sink (input valid, input median_value, input status, output ready);
endinterface

/* hw/rtl/rsm_cell.sv */
// rsm_cell: one slot of the sorted row, compare with the new sample and shift
// depends on rsm_pkg

module rsm_cell
  import rsm_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       empty,
  input  logic       left_big,
  input  sample_t    left_val,
  input  sample_t    right_val,
  output logic       big,
  output sample_t    val
);

  sample_t val_r;
  sample_t val_nxt;

  // an empty slot counts as larger than any sample
  assign big = empty || (val_r > ctrl.x);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.drain) begin
      val_nxt = right_val;
    end else if (ctrl.ins) begin
      if (left_big) begin
        val_nxt = left_val;
      end else if (big) begin
        val_nxt = ctrl.x;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* hw/rtl/rsm_row.sv */
// rsm_row: chain of rsm_cell slots holding the kept samples in ascending order
// depends on rsm_pkg, rsm_cell

module rsm_row
  import rsm_pkg::*;
#(
  parameter int N     = 32,
  parameter int CNT_W = 6
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] count,
  output sample_t          lo_val,
  output sample_t          hi_val
);

  localparam int HI_IDX = (N > 1) ? 1 : 0;

  sample_t   vals [N];
  logic [N-1:0] bigs;

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic    l_big;
    sample_t l_val;
    sample_t r_val;

    if (i == 0) begin : g_first
      assign l_big = 1'b0;
      assign l_val = ctrl.x;
    end else begin : g_mid
      assign l_big = bigs[i-1];
      assign l_val = vals[i-1];
    end

    if (i == N - 1) begin : g_last
      assign r_val = vals[i];
    end else begin : g_inner
      assign r_val = vals[i+1];
    end

    rsm_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .empty     (IDX >= count),
      .left_big  (l_big),
      .left_val  (l_val),
      .right_val (r_val),
      .big       (bigs[i]),
      .val       (vals[i])
    );
  end

  // after draining, the middle pair sits at the head of the row
  assign lo_val = vals[0];
  assign hi_val = vals[HI_IDX];

endmodule

/* hw/rtl/running_set_median_core.sv */
// running_set_median_core: median of a set of Q16.16 samples, sorted insertion row
// depends on rsm_pkg, rsm_if, rsm_row
//
//   channel    dir  handshake        payload
//   in_chan    in   valid / ready    sample (s32 Q16.16), last
//   out_chan   out  valid / ready    median_value (s33 Q16.17), status
//
// a sample that does not end a set is inserted in place by the row, or dropped if the row is full
// a set's last sample is handled in steps: the insertion, one row shift per position
// to bring the middle pair to the head, and the add into the output register
// the finished result waits in the output register while the next set fills;
// a later result waits in the drain state until that register is free
// rst_n is synchronous, active low, and empties the set; slot contents are not reset

module running_set_median_core
  import rsm_pkg::*;
#(
  parameter int MAX_SAMPLES = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  rsm_in_if.sink    in_chan,
  rsm_out_if.source out_chan
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  rsm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] shift_r, shift_nxt;
  logic             dropped_r, dropped_nxt;
  logic             out_valid_r, out_valid_nxt;
  median_t          median_r, median_nxt;
  logic             status_r, status_nxt;
  logic             load_out;

  cell_ctrl_t       ctrl;
  sample_t          lo_val;
  sample_t          hi_val;
  sample_t          hi_sel;
  median_t          pair_sum;
  logic             accept;
  logic             full;
  logic [CNT_W-1:0] count_after;
  logic [CNT_W-1:0] count_after_m1;

  rsm_row #(
    .N     (MAX_SAMPLES),
    .CNT_W (CNT_W)
  ) u_row (
    .clk    (clk),
    .ctrl   (ctrl),
    .count  (count_r),
    .lo_val (lo_val),
    .hi_val (hi_val)
  );

  assign in_chan.ready         = (state_r == S_FILL);
  assign accept                = in_chan.valid && in_chan.ready;
  assign full                  = (count_r == CNT_MAX);
  assign count_after           = full ? count_r : count_r + CNT_ONE;
  assign count_after_m1        = count_after - CNT_ONE;

  // odd count: twice the middle sample, even: sum of the middle pair
  assign hi_sel   = count_r[0] ? lo_val : hi_val;
  assign pair_sum = median_t'({lo_val[SAMPLE_W-1], lo_val})
                  + median_t'({hi_sel[SAMPLE_W-1], hi_sel});

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    shift_nxt     = shift_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    median_nxt    = median_r;
    status_nxt    = status_r;
    load_out      = 1'b0;
    ctrl.ins      = 1'b0;
    ctrl.drain    = 1'b0;
    ctrl.x        = in_chan.sample;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_FILL: begin
        if (accept) begin
          if (!full) begin
            ctrl.ins  = 1'b1;
            count_nxt = count_after;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_chan.last) begin
            state_nxt = S_DRAIN;
            shift_nxt = count_after_m1 >> 1;
          end
        end
      end
      S_DRAIN: begin
        if (shift_r != '0) begin
          ctrl.drain = 1'b1;
          shift_nxt  = shift_r - CNT_ONE;
        end else if (!out_valid_r || out_chan.ready) begin
          load_out      = 1'b1;
          median_nxt    = pair_sum;
          status_nxt    = dropped_r;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          dropped_nxt   = 1'b0;
          state_nxt     = S_FILL;
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      count_r     <= '0;
      shift_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      shift_r     <= shift_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median_r <= median_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.median_value = median_r;
  assign out_chan.status       = status_r;

endmodule

/* verif/running_set_median_core_tb.sv */
`timescale 1ns / 1ps
// running_set_median_core_tb: random and directed sets through the median core, checked
// against a sorted-insertion predictor kept in the bench; needs rsm_pkg, rsm_if and the core

module running_set_median_core_tb
  import rsm_pkg::*;
();

  localparam int SET_CAP   = 32;
  localparam int ITEM_GOAL = 1800;

  typedef struct {
    sample_t sample;
    logic    last;
  } set_item_t;

  typedef struct {
    median_t median_value;
    logic    status;
  } median_rec_t;

  logic clk = 1'b0;
  logic rst_n;

  rsm_in_if  in_chan ();
  rsm_out_if out_chan ();

  running_set_median_core #(.MAX_SAMPLES(SET_CAP)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_item_t   samples_to_send[$];
  median_rec_t medians_due[$];

  // bench copy of the sorted store
  sample_t ranked[SET_CAP];
  int      ranked_n = 0;
  logic    set_dropped = 1'b0;

  int      samples_taken = 0;
  int      sets_closed = 0;
  int      sets_overfilled = 0;
  int      medians_checked = 0;
  int      mismatches = 0;
  int      in_gap = 0;
  int      out_stall = 0;
  sample_t prev_pick = '0;
  logic [31:0] cyc = '0;
  logic    quiet;

  // every fourth stretch, while bits 9:8 of the cycle counter are both set, neither side starts a new idle gap
  assign quiet = (cyc[9:8] == 2'b11);

  always @(posedge clk) cyc <= cyc + 1;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $urandom;
      4, 5:       s = $signed($urandom_range(0, 64)) - 32;
      6: begin
        case ($urandom_range(0, 4))
          0:       s = 32'sh7FFF_FFFF;
          1:       s = 32'sh8000_0000;
          2:       s = '0;
          3:       s = -1;
          default: s = 1;
        endcase
      end
      7:          s = prev_pick;
      default:    s = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
    prev_pick = s;
    return s;
  endfunction

  task automatic queue_sample(input sample_t s, input logic l);
    set_item_t it;
    it.sample = s;
    it.last   = l;
    samples_to_send.insert(samples_to_send.size(), it);
  endtask

  task automatic queue_random_set(input int n);
    for (int i = 0; i < n; i++) queue_sample(rand_sample(), i == n - 1);
  endtask

  // insert one accepted sample; on the closing sample work out the median
  function automatic void fold_sample(input sample_t x, input logic is_last);
    int          pos;
    int          mid;
    median_rec_t rec;
    if (ranked_n < SET_CAP) begin
      pos = ranked_n;
      while (pos > 0 && ranked[pos-1] > x) begin
        ranked[pos] = ranked[pos-1];
        pos--;
      end
      ranked[pos] = x;
      ranked_n++;
    end else begin
      set_dropped = 1'b1;
    end
    samples_taken++;
    if (is_last) begin
      mid = ranked_n / 2;
      // Q16.17 result: twice the middle sample, or the sum of the middle pair
      if (ranked_n % 2 == 1) rec.median_value = median_t'(ranked[mid]) + median_t'(ranked[mid]);
      else rec.median_value = median_t'(ranked[mid]) + median_t'(ranked[mid-1]);
      rec.status = set_dropped;
      medians_due.insert(medians_due.size(), rec);
      sets_closed++;
      if (set_dropped) sets_overfilled++;
      ranked_n    = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // sample driver: holds each transaction until accepted, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        fold_sample(in_chan.sample, in_chan.last);
        samples_to_send.delete(0);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_chan.valid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          in_chan.valid  <= 1'b1;
          in_chan.sample <= samples_to_send[0].sample;
          in_chan.last   <= samples_to_send[0].last;
          if (!quiet && $urandom_range(0, 99) < 30) in_gap = pick_gap();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (medians_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: median %0d status %0b", $realtime,
                     out_chan.median_value, out_chan.status);
        end else begin
          if (out_chan.median_value !== medians_due[0].median_value ||
              out_chan.status !== medians_due[0].status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: median exp %0d got %0d, status exp %0b got %0b",
                       $realtime, medians_due[0].median_value, out_chan.median_value,
                       medians_due[0].status, out_chan.status);
          end
          medians_due.delete(0);
          medians_checked++;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 20) out_stall = pick_gap();
      end
    end
  end

  initial begin
    int n;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.sample = '0;
    in_chan.last   = 1'b0;
    out_chan.ready = 1'b0;

    // single-sample sets at the extremes
    queue_sample(32'sh7FFF_FFFF, 1'b1);
    queue_sample(32'sh8000_0000, 1'b1);
    queue_sample('0, 1'b1);
    // even sets: extremes mixed and doubled
    queue_sample(32'sh8000_0000, 1'b0);
    queue_sample(32'sh7FFF_FFFF, 1'b1);
    queue_sample(32'sh7FFF_FFFF, 1'b0);
    queue_sample(32'sh7FFF_FFFF, 1'b1);
    queue_sample(32'sh8000_0000, 1'b0);
    queue_sample(32'sh8000_0000, 1'b1);
    // descending arrival, odd count
    queue_sample(32'sh0003_0000, 1'b0);
    queue_sample(32'sh0002_0000, 1'b0);
    queue_sample(32'sh0001_0000, 1'b1);
    // equal samples, even count
    for (int i = 0; i < 4; i++) queue_sample(32'sh0000_7777, i == 3);
    // alternating bit patterns, then an odd set of -1, 1 and a near-minimum sample
    queue_sample(32'shAAAA_AAAA, 1'b0);
    queue_sample(32'sh5555_5555, 1'b1);
    queue_sample(-1, 1'b0);
    queue_sample(1, 1'b0);
    queue_sample(32'sh8000_0001, 1'b1);

    // store exactly full, then overfilled with the closing sample dropped
    queue_random_set(SET_CAP);
    queue_random_set(SET_CAP + 1 + $urandom_range(0, 7));
    while (samples_to_send.size() < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: n = $urandom_range(1, 8);
        7, 8:                n = $urandom_range(9, SET_CAP);
        default:             n = $urandom_range(SET_CAP + 1, SET_CAP + 8);
      endcase
      queue_random_set(n);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (samples_to_send.size() != 0 || medians_due.size() != 0) @(posedge clk);
    // leave room for a stray result after the last drain
    repeat (60) @(posedge clk);

    $display("covered %0d samples in %0d sets, %0d of them past capacity",
             samples_taken, sets_closed, sets_overfilled);
    $display("compared %0d medians, %0d mismatches", medians_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timed out with %0d samples and %0d medians outstanding",
             samples_to_send.size(), medians_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule
